@@ hw/rtl/qbf_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the quadratic bezier flattener
package qbf_pkg;

  localparam int COORD_W      = 24;
  localparam int CFG_W        = 7;
  localparam int MIN_SEGMENTS = 5;

  typedef logic signed [COORD_W-1:0] qbf_coord_t;

  typedef struct packed {
    qbf_coord_t start_x;
    qbf_coord_t start_y;
    qbf_coord_t ctrl_x;
    qbf_coord_t ctrl_y;
    qbf_coord_t end_x;
    qbf_coord_t end_y;
  } qbf_seg_t;

  typedef struct packed {
    qbf_coord_t point_x;
    qbf_coord_t point_y;
    logic       last_point;
  } qbf_pt_t;

  typedef struct packed {
    logic start;
    logic step;
    logic fix;
  } qbf_div_cmd_t;

  typedef struct packed {
    qbf_div_cmd_t div;
    logic         latch;
    logic         load;
    logic         emit;
    logic         last;
  } qbf_cmd_t;

endpackage

@@ hw/rtl/qbf_intf.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for segments, points and configuration
interface qbf_seg_if import qbf_pkg::*; ();
  logic       valid;
  logic       ready;
  qbf_coord_t start_x;
  qbf_coord_t start_y;
  qbf_coord_t ctrl_x;
  qbf_coord_t ctrl_y;
  qbf_coord_t end_x;
  qbf_coord_t end_y;

  modport source (
    output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
    output ready
  );
endinterface

interface qbf_pt_if import qbf_pkg::*; ();
  logic       valid;
  logic       ready;
  qbf_coord_t point_x;
  qbf_coord_t point_y;
  logic       last_point;

  modport source (
    output valid, point_x, point_y, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, last_point,
    output ready
  );
endinterface

interface qbf_cfg_if import qbf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] segments_per_curve;

  modport source (
    output valid, segments_per_curve,
    input  ready
  );
  modport sink (
    input  valid, segments_per_curve,
    output ready
  );
endinterface

@@ hw/rtl/qbf_divider.sv @@
`timescale 1ns / 1ps
// restoring bit-serial floor divider, one quotient bit per step
module qbf_divider import qbf_pkg::*; #(
  parameter int MAG_W = 32,
  parameter int D_W   = 13
) (
  input  logic                    clk_i,
  input  qbf_div_cmd_t            cmd_i,
  input  logic signed [MAG_W:0]   dividend_i,
  input  logic        [D_W-1:0]   divisor_i,
  output qbf_coord_t              quot_o,
  output logic        [D_W-1:0]   rem_o
);

  logic [MAG_W-1:0] quot_q, quot_d;
  logic [D_W-1:0]   rem_q, rem_d;
  logic             neg_q, neg_d;
  logic [D_W:0]     trial;
  logic             ge;
  logic [MAG_W:0]   mag;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    mag    = dividend_i[MAG_W] ? (MAG_W+1)'(-dividend_i) : (MAG_W+1)'(dividend_i);
    trial  = {rem_q, quot_q[MAG_W-1]};
    ge     = trial >= {1'b0, divisor_i};
    if (cmd_i.start) begin
      quot_d = mag[MAG_W-1:0];
      rem_d  = '0;
      neg_d  = dividend_i[MAG_W];
    end else if (cmd_i.step) begin
      quot_d = {quot_q[MAG_W-2:0], ge};
      rem_d  = ge ? D_W'(trial - {1'b0, divisor_i}) : trial[D_W-1:0];
    end else if (cmd_i.fix && neg_q) begin
      // floor for negative dividends
      if (rem_q != '0) begin
        quot_d = ~quot_q;
        rem_d  = divisor_i - rem_q;
      end else begin
        quot_d = -quot_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
  end

  assign quot_o = quot_q[COORD_W-1:0];
  assign rem_o  = rem_q;

endmodule

@@ hw/rtl/qbf_datapath.sv @@
`timescale 1ns / 1ps
// datapath: config register, segment latch, dividers and quotient/remainder stepping
module qbf_datapath import qbf_pkg::*; #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  qbf_cmd_t                             cmd_i,
  input  logic                                 cfg_we_i,
  input  logic [CFG_W-1:0]                     cfg_data_i,
  input  qbf_seg_t                             seg_i,
  output logic [$clog2(MAX_SEGMENTS+1)-1:0]    n_o,
  output qbf_pt_t                              pt_o
);

  localparam int N_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int D_W   = $clog2(MAX_SEGMENTS * MAX_SEGMENTS + 1);
  localparam int MAG_W = COORD_W + $clog2(2 * MAX_SEGMENTS + 2);
  localparam int DIV_W = MAG_W + 1;
  localparam int P_W   = N_W + COORD_W + 3;

  function automatic logic [D_W:0] radd(input logic [D_W-1:0] x, input logic [D_W-1:0] y,
                                        input logic [D_W-1:0] dd);
    logic [D_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, dd}) begin
      radd = {1'b1, D_W'(s - {1'b0, dd})};
    end else begin
      radd = {1'b0, s[D_W-1:0]};
    end
  endfunction

  logic [N_W-1:0]   n_q;
  logic [CFG_W-1:0] clamp;
  logic [D_W-1:0]   d_q;

  qbf_coord_t p0_q [2];
  qbf_coord_t p1_q [2];
  qbf_coord_t p2_q [2];
  // running value and first/second differences, quotient and remainder by n^2
  qbf_coord_t     nq_q [2], nq_d [2];
  logic [D_W-1:0] nr_q [2], nr_d [2];
  qbf_coord_t     q1_q [2], q1_d [2];
  logic [D_W-1:0] r1_q [2], r1_d [2];
  qbf_coord_t     q2_q [2], q2_d [2];
  logic [D_W-1:0] r2_q [2], r2_d [2];
  qbf_coord_t     out_q [2], out_d [2];
  logic           last_q;

  logic signed [N_W+1:0]   two_n;
  logic signed [COORD_W:0] dp   [2];
  logic signed [P_W-1:0]   prod [2];
  logic signed [DIV_W-1:0] dva  [2];
  logic signed [DIV_W-1:0] dv1  [2];
  qbf_coord_t              qa   [2];
  qbf_coord_t              qd   [2];
  logic [D_W-1:0]          ra   [2];
  logic [D_W-1:0]          rd   [2];
  logic [D_W:0]            r2x  [2];
  logic                    ge2  [2];
  logic [D_W-1:0]          r2n  [2];
  qbf_coord_t              q2n  [2];
  logic [D_W:0]            sl   [2];
  logic [D_W:0]            sn   [2];
  logic [D_W:0]            s1   [2];
  logic [D_W:0]            rr   [2];
  logic                    up   [2];

  always_comb begin
    if (cfg_data_i < CFG_W'(MIN_SEGMENTS)) begin
      clamp = CFG_W'(MIN_SEGMENTS);
    end else if (cfg_data_i > CFG_W'(MAX_SEGMENTS)) begin
      clamp = CFG_W'(MAX_SEGMENTS);
    end else begin
      clamp = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= N_W'(MIN_SEGMENTS);
    end else if (cfg_we_i) begin
      n_q <= N_W'(clamp);
    end
  end

  assign two_n = signed'({1'b0, n_q, 1'b0});

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      // divider operands: A = p0 - 2 p1 + p2, first difference 2n (p1 - p0) + A
      dp[a]   = (COORD_W+1)'(p1_q[a]) - (COORD_W+1)'(p0_q[a]);
      prod[a] = P_W'(two_n) * P_W'(dp[a]);
      dva[a]  = DIV_W'(p0_q[a]) - DIV_W'(p1_q[a]) - DIV_W'(p1_q[a]) + DIV_W'(p2_q[a]);
      dv1[a]  = DIV_W'(prod[a]) + dva[a];

      // second difference is 2A
      r2x[a] = {ra[a], 1'b0};
      ge2[a] = r2x[a] >= {1'b0, d_q};
      r2n[a] = ge2[a] ? D_W'(r2x[a] - {1'b0, d_q}) : r2x[a][D_W-1:0];
      q2n[a] = {qa[a][COORD_W-2:0], ge2[a]};
      sl[a]  = radd(rd[a], r2n[a], d_q);

      sn[a] = radd(nr_q[a], r1_q[a], d_q);
      s1[a] = radd(r1_q[a], r2_q[a], d_q);

      // round half away from zero
      rr[a] = {nr_q[a], 1'b0};
      up[a] = (rr[a] > {1'b0, d_q}) || ((rr[a] == {1'b0, d_q}) && !nq_q[a][COORD_W-1]);

      nq_d[a]  = nq_q[a];
      nr_d[a]  = nr_q[a];
      q1_d[a]  = q1_q[a];
      r1_d[a]  = r1_q[a];
      q2_d[a]  = q2_q[a];
      r2_d[a]  = r2_q[a];
      out_d[a] = out_q[a];
      if (cmd_i.load) begin
        nq_d[a] = p0_q[a] + qd[a];
        nr_d[a] = rd[a];
        q1_d[a] = qd[a] + q2n[a] + COORD_W'(sl[a][D_W]);
        r1_d[a] = sl[a][D_W-1:0];
        q2_d[a] = q2n[a];
        r2_d[a] = r2n[a];
      end else if (cmd_i.emit) begin
        out_d[a] = nq_q[a] + COORD_W'(up[a]);
        nq_d[a]  = nq_q[a] + q1_q[a] + COORD_W'(sn[a][D_W]);
        nr_d[a]  = sn[a][D_W-1:0];
        q1_d[a]  = q1_q[a] + q2_q[a] + COORD_W'(s1[a][D_W]);
        r1_d[a]  = s1[a][D_W-1:0];
      end
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    qbf_divider #(
      .MAG_W (MAG_W),
      .D_W   (D_W)
    ) u_div_a (
      .clk_i      (clk_i),
      .cmd_i      (cmd_i.div),
      .dividend_i (dva[a]),
      .divisor_i  (d_q),
      .quot_o     (qa[a]),
      .rem_o      (ra[a])
    );

    qbf_divider #(
      .MAG_W (MAG_W),
      .D_W   (D_W)
    ) u_div_d1 (
      .clk_i      (clk_i),
      .cmd_i      (cmd_i.div),
      .dividend_i (dv1[a]),
      .divisor_i  (d_q),
      .quot_o     (qd[a]),
      .rem_o      (rd[a])
    );
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      p0_q[0] <= seg_i.start_x;
      p0_q[1] <= seg_i.start_y;
      p1_q[0] <= seg_i.ctrl_x;
      p1_q[1] <= seg_i.ctrl_y;
      p2_q[0] <= seg_i.end_x;
      p2_q[1] <= seg_i.end_y;
      d_q     <= D_W'(n_q) * D_W'(n_q);
    end
    if (cmd_i.emit) begin
      last_q <= cmd_i.last;
    end
    for (int a = 0; a < 2; a++) begin
      nq_q[a]  <= nq_d[a];
      nr_q[a]  <= nr_d[a];
      q1_q[a]  <= q1_d[a];
      r1_q[a]  <= r1_d[a];
      q2_q[a]  <= q2_d[a];
      r2_q[a]  <= r2_d[a];
      out_q[a] <= out_d[a];
    end
  end

  assign n_o             = n_q;
  assign pt_o.point_x    = out_q[0];
  assign pt_o.point_y    = out_q[1];
  assign pt_o.last_point = last_q;

endmodule

@@ hw/rtl/qbf_controller.sv @@
`timescale 1ns / 1ps
// control state machine: segment intake, divide sequencing, point emission
module qbf_controller import qbf_pkg::*; #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic [$clog2(MAX_SEGMENTS+1)-1:0] n_i,
  output qbf_cmd_t                          cmd_o
);

  localparam int N_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int MAG_W = COORD_W + $clog2(2 * MAX_SEGMENTS + 2);
  localparam int CNT_W = $clog2(MAG_W);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_FIX   = 6'b001000,
    ST_LOAD  = 6'b010000,
    ST_EMIT  = 6'b100000
  } qbf_state_e;

  qbf_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [N_W-1:0]   pt_q, pt_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pt_d        = pt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_START;
        end
      end
      ST_START: begin
        cmd_o.div.start = 1'b1;
        cnt_d           = CNT_W'(MAG_W - 1);
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_FIX: begin
        cmd_o.div.fix = 1'b1;
        state_d       = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        pt_d       = N_W'(1);
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.last  = pt_q == n_i;
          out_valid_d = 1'b1;
          pt_d        = pt_q + 1'b1;
          if (pt_q == n_i) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pt_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pt_q        <= pt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_START))
    else $error("accepted segment did not start the divide");

  a_fix_after_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIX) |-> ($past(state_q) == ST_DIV && $past(cnt_q) == '0))
    else $error("divide cut short");

  a_load_first_pt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |=> (state_q == ST_EMIT && pt_q == N_W'(1)))
    else $error("point count not primed after load");

  a_last_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("last point did not close the segment");

endmodule

@@ hw/rtl/quadratic_bezier_flattener.sv @@
`timescale 1ns / 1ps
// top level of the quadratic bezier flattener
//
//   channel  | dir | beat
//   ---------+-----+-----------------------------------------------------
//   in_if    | in  | one segment: start, control and end point, x and y
//   out_if   | out | one curve point x, y with last_point on the end point
//   cfg_if   | in  | segments_per_curve, clamped to 5..MAX_SEGMENTS
//
// after a segment is accepted, the bit-serial dividers reduce the difference terms
// by N^2, MAG_W being their step count; points then leave one per cycle while
// out_if.ready stays high
// reset clears the state machine and output valid, and sets N to 5
// in_if.ready is high only between segments; a low out_if.ready holds the point
// and pauses emission
module quadratic_bezier_flattener import qbf_pkg::*; #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qbf_seg_if.sink    in_if,
  qbf_pt_if.source   out_if,
  qbf_cfg_if.sink    cfg_if
);

  localparam int N_W = $clog2(MAX_SEGMENTS + 1);

  qbf_cmd_t       cmd;
  qbf_seg_t       seg;
  qbf_pt_t        pt;
  logic [N_W-1:0] n;
  logic           in_ready;
  logic           out_valid;

  assign seg.start_x = in_if.start_x;
  assign seg.start_y = in_if.start_y;
  assign seg.ctrl_x  = in_if.ctrl_x;
  assign seg.ctrl_y  = in_if.ctrl_y;
  assign seg.end_x   = in_if.end_x;
  assign seg.end_y   = in_if.end_y;

  assign cfg_if.ready = 1'b1;

  qbf_controller #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .n_i         (n),
    .cmd_o       (cmd)
  );

  qbf_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_if.valid),
    .cfg_data_i (cfg_if.segments_per_curve),
    .seg_i      (seg),
    .n_o        (n),
    .pt_o       (pt)
  );

  assign in_if.ready       = in_ready;
  assign out_if.valid      = out_valid;
  assign out_if.point_x    = pt.point_x;
  assign out_if.point_y    = pt.point_y;
  assign out_if.last_point = pt.last_point;

endmodule

@@ sim/tb_quadratic_bezier_flattener.sv @@
`timescale 1ns / 1ps
// testbench for the quadratic bezier flattener: predicts each curve point and checks every beat
module tb_quadratic_bezier_flattener;
  import qbf_pkg::*;

  localparam int MAX_SEGMENTS   = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 43;
  localparam int PRESSURE_ITEMS = 6;

  localparam qbf_coord_t COORD_MAX = qbf_coord_t'(24'h7fffff);
  localparam qbf_coord_t COORD_MIN = qbf_coord_t'(24'h800000);

  logic clk_i = 1'b0;
  logic rst_ni;

  qbf_seg_if seg_if ();
  qbf_pt_if  pt_if ();
  qbf_cfg_if cfg_if ();

  logic [CFG_W-1:0] segment_count_reg = CFG_W'(MIN_SEGMENTS);
  qbf_pt_t          pending_points[$];
  qbf_pt_t          next_point;
  int               error_count    = 0;
  int               stall_cycles   = 0;
  int               point_hold_len = 0;
  bit               tx_idle        = 1'b0;
  bit               rx_idle        = 1'b0;

  quadratic_bezier_flattener #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (seg_if),
    .out_if (pt_if),
    .cfg_if (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  function automatic qbf_coord_t curve_coord(qbf_coord_t a, qbf_coord_t b, qbf_coord_t c,
                                             int n, int j);
    longint nn;
    longint jj;
    longint u;
    longint num;
    longint den;
    longint mag;
    longint q;
    nn  = longint'(n);
    jj  = longint'(j);
    u   = nn - jj;
    num = u * u * longint'(a) + 64'sd2 * u * jj * longint'(b) + jj * jj * longint'(c);
    den = nn * nn;
    mag = (num < 64'sd0) ? -num : num;
    // nearest, ties away from zero
    q   = (64'sd2 * mag + den) / (64'sd2 * den);
    return qbf_coord_t'((num < 64'sd0) ? -q : q);
  endfunction

  function automatic void predict_curve_points(qbf_seg_t seg);
    int      n;
    qbf_pt_t pt;
    n = int'(segment_count_reg);
    if (n < MIN_SEGMENTS) begin
      n = MIN_SEGMENTS;
    end else if (n > MAX_SEGMENTS) begin
      n = MAX_SEGMENTS;
    end
    for (int j = 1; j <= n; j++) begin
      pt.point_x    = curve_coord(seg.start_x, seg.ctrl_x, seg.end_x, n, j);
      pt.point_y    = curve_coord(seg.start_y, seg.ctrl_y, seg.end_y, n, j);
      pt.last_point = (j == n);
      pending_points.push_back(pt);
    end
  endfunction

  function automatic qbf_coord_t random_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3: return qbf_coord_t'(int'($urandom_range(0, 4095)) - 2048);
      default: return qbf_coord_t'($urandom);
    endcase
  endfunction

  function automatic qbf_seg_t random_segment();
    qbf_seg_t seg;
    seg.start_x = random_coord();
    seg.start_y = random_coord();
    seg.ctrl_x  = random_coord();
    seg.ctrl_y  = random_coord();
    seg.end_x   = random_coord();
    seg.end_y   = random_coord();
    return seg;
  endfunction

  function automatic qbf_seg_t make_segment(qbf_coord_t x0, qbf_coord_t y0, qbf_coord_t x1,
                                            qbf_coord_t y1, qbf_coord_t x2, qbf_coord_t y2);
    qbf_seg_t seg;
    seg = '{start_x: x0, start_y: y0, ctrl_x: x1, ctrl_y: y1, end_x: x2, end_y: y2};
    return seg;
  endfunction

  // called just after a rising edge; returns at the edge that accepts the beat
  task automatic send_segment(qbf_seg_t seg);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    repeat (gap) begin
      seg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    seg_if.valid   <= 1'b1;
    seg_if.start_x <= seg.start_x;
    seg_if.start_y <= seg.start_y;
    seg_if.ctrl_x  <= seg.ctrl_x;
    seg_if.ctrl_y  <= seg.ctrl_y;
    seg_if.end_x   <= seg.end_x;
    seg_if.end_y   <= seg.end_y;
    do @(posedge clk_i); while (!seg_if.ready);
    predict_curve_points(seg);
  endtask

  task automatic drain_points();
    seg_if.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_segment_count(logic [CFG_W-1:0] value);
    drain_points();
    cfg_if.valid              <= 1'b1;
    cfg_if.segments_per_curve <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid      <= 1'b0;
    segment_count_reg = value;
  endtask

  task automatic test_reset_default();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_segment(make_segment('0, '0, '0, '0, '0, '0));
    send_segment(make_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_segment(make_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_segment(make_segment(COORD_MAX, COORD_MIN, '0, '0, COORD_MIN, COORD_MAX));
    send_segment(make_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, -1));
  endtask

  // even counts give exact halves at the midpoint
  task automatic test_rounding_ties();
    write_segment_count(7'd8);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_segment(make_segment(2, -2, '0, '0, '0, '0));
    send_segment(make_segment(-2, 2, '0, '0, '0, '0));
    send_segment(make_segment('0, '0, 1, -1, '0, '0));
  endtask

  task automatic test_segment_count_range();
    logic [CFG_W-1:0] counts[8];
    counts = '{7'd0, 7'd4, 7'd5, 7'd6, 7'd63, 7'd64, 7'd65, 7'd127};
    foreach (counts[i]) begin
      write_segment_count(counts[i]);
      tx_idle = i[0];
      rx_idle = i[1];
      send_segment(make_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN));
      send_segment(random_segment());
    end
  endtask

  // long output stall while segments keep coming
  task automatic test_backpressure();
    write_segment_count(7'd64);
    tx_idle        = 1'b0;
    rx_idle        = 1'b1;
    point_hold_len = HOLD_CYCLES;
    for (int i = 0; i < PRESSURE_ITEMS; i++) begin
      send_segment(random_segment());
    end
  endtask

  task automatic test_random_segments();
    logic [CFG_W-1:0] count;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: count = 7'd64;
        1: count = 7'd0;
        2: count = 7'd127;
        default: begin
          count = ($urandom_range(0, 3) != 0) ? CFG_W'($urandom_range(0, 16)) :
                                                CFG_W'($urandom_range(0, 127));
        end
      endcase
      write_segment_count(count);
      tx_idle = (phase % 3) != 0;
      rx_idle = (phase % 4) != 1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_segment(random_segment());
      end
    end
  endtask

  initial begin : point_receiver
    int gap;
    pt_if.ready <= 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      if (point_hold_len > 0) begin
        gap            = point_hold_len;
        point_hold_len = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 11) : 0;
      end
      repeat (gap) begin
        pt_if.ready <= 1'b0;
        @(posedge clk_i);
      end
      pt_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(pt_if.valid && pt_if.ready));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pt_if.valid && pt_if.ready) begin
      if (pending_points.size() == 0) begin
        error_count++;
        $error("point beat with none pending: point_x %0d point_y %0d last_point %0b",
               pt_if.point_x, pt_if.point_y, pt_if.last_point);
      end else begin
        next_point = pending_points.pop_front();
        if (pt_if.point_x !== next_point.point_x) begin
          error_count++;
          $error("point_x expected %0d actual %0d", next_point.point_x, pt_if.point_x);
        end
        if (pt_if.point_y !== next_point.point_y) begin
          error_count++;
          $error("point_y expected %0d actual %0d", next_point.point_y, pt_if.point_y);
        end
        if (pt_if.last_point !== next_point.last_point) begin
          error_count++;
          $error("last_point expected %0b actual %0b", next_point.last_point, pt_if.last_point);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((seg_if.valid && seg_if.ready) || (pt_if.valid && pt_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni                    <= 1'b0;
    seg_if.valid              <= 1'b0;
    seg_if.start_x            <= '0;
    seg_if.start_y            <= '0;
    seg_if.ctrl_x             <= '0;
    seg_if.ctrl_y             <= '0;
    seg_if.end_x              <= '0;
    seg_if.end_y              <= '0;
    cfg_if.valid              <= 1'b0;
    cfg_if.segments_per_curve <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_default();
    test_rounding_ties();
    test_segment_count_range();
    test_backpressure();
    test_random_segments();
    drain_points();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
